FILE: src/escu_pkg.sv
// escu_pkg: types, constants and pipeline depths shared by the sensor compensation blocks
// used by every module under src
package escu_pkg;

	localparam int unsigned QueueDepth = 2;
	localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
	localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

	localparam int unsigned PreStages  = 14;
	localparam int unsigned DivSteps   = 64;
	localparam int unsigned PostStages = 7;

	localparam logic [63:0] PressOffset  = 64'd128000;
	localparam logic [20:0] PressRawBase = 21'd1048576;
	localparam logic [15:0] PressScale   = 16'd3125;
	localparam logic [63:0] PressBias    = 64'h0000_8000_0000_0000;
	localparam logic [31:0] HumOffset    = 32'd76800;
	localparam logic [31:0] HumClampMax  = 32'd419430400;
	localparam logic [16:0] HumOutMax    = 17'd102400;
	localparam logic [31:0] HumRound     = 32'd16384;
	localparam logic [31:0] HumHalf      = 32'd32768;
	localparam logic [31:0] HumBase      = 32'd2097152;
	localparam logic [31:0] HumRoundY    = 32'd8192;
	localparam logic [31:0] TempRound    = 32'd128;

	typedef enum logic [2:0] {
		REG_TEMP      = 3'd0,
		REG_PRESS_LO  = 3'd1,
		REG_PRESS_HI  = 3'd2,
		REG_PRESS_HUM = 3'd3,
		REG_HUM       = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic        [15:0] p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
		logic        [7:0]  h1;
		logic signed [15:0] h2;
		logic        [7:0]  h3;
		logic        [11:0] h4;
		logic signed [11:0] h5;
		logic signed [7:0]  h6;
	} coef_t;

	typedef struct packed {
		logic [19:0] at;
		logic [19:0] ap;
		logic [15:0] ah;
	} raw_t;

	typedef struct packed {
		logic [31:0] temp;
		logic [16:0] hum;
		logic        inval;
	} side_t;

	typedef struct packed {
		logic [63:0] num;
		logic [63:0] den;
		side_t       side;
	} div_in_t;

	typedef struct packed {
		logic [63:0] quo;
		logic        neg;
		side_t       side;
	} div_out_t;

endpackage

FILE: src/escu_front.sv
// escu_front: input side, takes raw readings into a short queue ahead of the compute pipeline
// depends on escu_pkg
module escu_front import escu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  raw_t push_item,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output raw_t head_item
);

	raw_t                 entry_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q;
	logic [QueuePtrW-1:0] rd_ptr_q;
	logic [QueueCntW-1:0] cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign full       = (cnt_q == QueueCntW'(QueueDepth));
	assign head_valid = (cnt_q != '0);
	assign head_item  = entry_q[rd_ptr_q];
	assign do_push    = push_valid && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/escu_pre.sv
// escu_pre: temperature, humidity and the pressure numerator / divisor, one item per cycle while adv is high
// depends on escu_pkg
module escu_pre import escu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  logic    in_valid,
	input  raw_t    in_raw,
	input  coef_t   coef,
	output logic    out_valid,
	output div_in_t out_item
);

	typedef struct packed {
		raw_t        raw;
		logic [31:0] m1;
		logic [31:0] dd;
		logic [31:0] v1;
		logic [31:0] m2;
		logic [31:0] tf;
		logic [31:0] temp;
		logic [31:0] hv;
		logic [31:0] mh5;
		logic [31:0] mh6;
		logic [31:0] mh3;
		logic [31:0] hx;
		logic [31:0] ya;
		logic [31:0] yb;
		logic [31:0] y;
		logic [31:0] y2;
		logic [31:0] y3a;
		logic [31:0] y3;
		logic [31:0] hv2;
		logic [31:0] qq;
		logic [31:0] tt;
		logic [16:0] hum;
		logic [63:0] a;
		logic [63:0] aa;
		logic [63:0] ap2;
		logic [63:0] ap5;
		logic [63:0] bl;
		logic [31:0] bh;
		logic [63:0] cl;
		logic [31:0] ch;
		logic [63:0] b;
		logic [63:0] cs;
		logic [63:0] x;
		logic [63:0] xl;
		logic [31:0] xh;
		logic [63:0] den;
		logic [63:0] n0;
		logic [63:0] nl;
		logic [31:0] nh;
		logic [63:0] num;
	} pre_t;

	function automatic pre_t pre_step(input int unsigned k, input pre_t i, input coef_t c);
		pre_t               o;
		logic signed [17:0] dt;
		logic signed [18:0] et;
		logic signed [34:0] pr35;
		logic signed [35:0] pr36;
		logic signed [43:0] pr44;
		logic signed [47:0] pr48;
		logic signed [48:0] pr49;
		logic signed [63:0] pr64;
		logic signed [65:0] pr66;
		logic        [47:0] pu48;
		logic signed [31:0] s32a;
		logic signed [31:0] s32b;
		logic signed [63:0] s64a;
		logic        [20:0] pm;
		logic        [31:0] vf;
		o = i;
		case (k)
			1: begin
				dt   = $signed({2'b0, i.raw.at[19:4]}) - $signed({2'b0, c.t1});
				et   = $signed({2'b0, i.raw.at[19:3]}) - $signed({2'b0, c.t1, 1'b0});
				pr35 = et * $signed(c.t2);
				o.m1 = pr35[31:0];
				pr36 = dt * dt;
				o.dd = pr36[31:0];
			end
			2: begin
				s32a = $signed(i.m1) >>> 11;
				o.v1 = s32a;
				s32b = $signed(i.dd) >>> 12;
				pr48 = s32b * $signed(c.t3);
				o.m2 = pr48[31:0];
			end
			3: begin
				s32a = $signed(i.m2) >>> 14;
				o.tf = i.v1 + s32a;
			end
			4: begin
				s32a   = $signed((i.tf << 2) + i.tf + TempRound) >>> 8;
				o.temp = s32a;
				o.a    = {{32{i.tf[31]}}, i.tf} - PressOffset;
				o.hv   = i.tf - HumOffset;
			end
			5: begin
				pr66  = $signed(i.a[32:0]) * $signed(i.a[32:0]);
				o.aa  = pr66[63:0];
				pr49  = $signed(i.a[32:0]) * $signed(c.p2);
				o.ap2 = {{15{pr49[48]}}, pr49};
				pr49  = $signed(i.a[32:0]) * $signed(c.p5);
				o.ap5 = {{15{pr49[48]}}, pr49};
				pr44  = $signed(i.hv) * $signed(c.h5);
				o.mh5 = pr44[31:0];
				pr44  = $signed(i.hv) * $signed(c.h6);
				o.mh6 = pr44[31:0];
				pr44  = $signed(i.hv) * $signed({1'b0, c.h3});
				o.mh3 = pr44[31:0];
			end
			6: begin
				// 64-bit products by a 16-bit coefficient, split in 32-bit halves
				pr49 = $signed({1'b0, i.aa[31:0]}) * $signed(c.p6);
				o.bl = {{15{pr49[48]}}, pr49};
				pr48 = $signed(i.aa[63:32]) * $signed(c.p6);
				o.bh = pr48[31:0];
				pr49 = $signed({1'b0, i.aa[31:0]}) * $signed(c.p3);
				o.cl = {{15{pr49[48]}}, pr49};
				pr48 = $signed(i.aa[63:32]) * $signed(c.p3);
				o.ch = pr48[31:0];
				s32a = $signed({2'b0, i.raw.ah, 14'b0} - {c.h4, 20'b0} - i.mh5 + HumRound) >>> 15;
				o.hx = s32a;
				s32b = $signed(i.mh6) >>> 10;
				o.ya = s32b;
				s32a = $signed(i.mh3) >>> 11;
				o.yb = s32a + HumHalf;
			end
			7: begin
				o.b  = i.bl + {i.bh, 32'b0} + {i.ap5[46:0], 17'b0}
					+ {{13{c.p4[15]}}, c.p4, 35'b0};
				o.cs = i.cl + {i.ch, 32'b0};
				pr64 = $signed(i.ya) * $signed(i.yb);
				o.y  = pr64[31:0];
			end
			8: begin
				s64a = $signed(i.cs) >>> 8;
				o.x  = s64a + {i.ap2[51:0], 12'b0} + PressBias;
				s32a = $signed(i.y) >>> 10;
				o.y2 = s32a + HumBase;
			end
			9: begin
				pu48  = i.x[31:0] * c.p1;
				o.xl  = {16'b0, pu48};
				pu48  = i.x[63:32] * c.p1;
				o.xh  = pu48[31:0];
				pr48  = $signed(i.y2) * $signed(c.h2);
				o.y3a = pr48[31:0];
			end
			10: begin
				s64a  = $signed(i.xl + {i.xh, 32'b0}) >>> 33;
				o.den = s64a;
				pm    = PressRawBase - {1'b0, i.raw.ap};
				o.n0  = {12'b0, pm, 31'b0} - i.b;
				s32a  = $signed(i.y3a + HumRoundY) >>> 14;
				o.y3  = s32a;
			end
			11: begin
				pu48  = i.n0[31:0] * PressScale;
				o.nl  = {16'b0, pu48};
				pu48  = i.n0[63:32] * PressScale;
				o.nh  = pu48[31:0];
				pr64  = $signed(i.hx) * $signed(i.y3);
				o.hv2 = pr64[31:0];
			end
			12: begin
				o.num = i.nl + {i.nh, 32'b0};
				s32a  = $signed(i.hv2) >>> 15;
				pr64  = s32a * s32a;
				o.qq  = pr64[31:0];
			end
			13: begin
				s32a = $signed(i.qq) >>> 7;
				pr44 = s32a * $signed({1'b0, c.h1});
				o.tt = pr44[31:0];
			end
			14: begin
				s32a = $signed(i.tt) >>> 4;
				vf   = i.hv2 - s32a;
				// clamp to the humidity range before dropping 12 fraction bits
				if (vf[31]) begin
					o.hum = '0;
				end else if (vf > HumClampMax) begin
					o.hum = HumOutMax;
				end else begin
					o.hum = vf[28:12];
				end
			end
			default: begin
				o = i;
			end
		endcase
		return o;
	endfunction

	pre_t                 pre_in;
	pre_t                 pre_d [1:PreStages];
	pre_t                 pre_s [1:PreStages];
	logic [PreStages:1]   vld_s;

	always_comb begin
		pre_in     = '0;
		pre_in.raw = in_raw;
	end

	for (genvar g = 1; g <= PreStages; g++) begin : g_stage
		if (g == 1) begin : g_first
			assign pre_d[g] = pre_step(g, pre_in, coef);
		end else begin : g_next
			assign pre_d[g] = pre_step(g, pre_s[g-1], coef);
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				pre_s[g] <= pre_d[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[PreStages-1:1], in_valid};
		end
	end

	assign out_valid           = vld_s[PreStages];
	assign out_item.num        = pre_s[PreStages].num;
	assign out_item.den        = pre_s[PreStages].den;
	assign out_item.side.temp  = pre_s[PreStages].temp;
	assign out_item.side.hum   = pre_s[PreStages].hum;
	assign out_item.side.inval = (pre_s[PreStages].den == '0);

endmodule

FILE: src/escu_div.sv
// escu_div: pipelined signed 64-bit divide, one quotient bit per stage, truncating toward zero
// depends on escu_pkg
module escu_div import escu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  logic     in_valid,
	input  div_in_t  in_item,
	output logic     out_valid,
	output div_out_t out_item
);

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] quo;
		logic [63:0] dvs;
		logic        neg;
		side_t       side;
	} div_t;

	function automatic div_t div_step(input div_t i);
		div_t        o;
		logic [64:0] r;
		logic [64:0] diff;
		o    = i;
		r    = {i.rem, i.quo[63]};
		diff = r - {1'b0, i.dvs};
		if (!diff[64]) begin
			o.rem = diff[63:0];
			o.quo = {i.quo[62:0], 1'b1};
		end else begin
			o.rem = r[63:0];
			o.quo = {i.quo[62:0], 1'b0};
		end
		return o;
	endfunction

	div_t              ent;
	div_t              div_s [0:DivSteps];
	logic [DivSteps:0] vld_s;

	// magnitudes; a zero divisor is replaced so the pipeline stays well defined
	always_comb begin
		ent.rem  = '0;
		ent.quo  = in_item.num[63] ? (64'd0 - in_item.num) : in_item.num;
		if (in_item.side.inval) begin
			ent.dvs = 64'd1;
		end else begin
			ent.dvs = in_item.den[63] ? (64'd0 - in_item.den) : in_item.den;
		end
		ent.neg  = in_item.num[63] ^ in_item.den[63];
		ent.side = in_item.side;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0] <= ent;
		end
	end

	for (genvar g = 1; g <= DivSteps; g++) begin : g_step
		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[g] <= div_step(div_s[g-1]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[DivSteps-1:0], in_valid};
		end
	end

	assign out_valid     = vld_s[DivSteps];
	assign out_item.quo  = div_s[DivSteps].quo;
	assign out_item.neg  = div_s[DivSteps].neg;
	assign out_item.side = div_s[DivSteps].side;

endmodule

FILE: src/escu_post.sv
// escu_post: pressure correction terms after the divide, ends in the result register
// depends on escu_pkg
module escu_post import escu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  logic     in_valid,
	input  div_out_t in_item,
	input  coef_t    coef,
	output logic     out_valid,
	output side_t    out_side,
	output logic [31:0] out_pres
);

	typedef struct packed {
		logic [63:0] p;
		logic [63:0] ll;
		logic [31:0] lh;
		logic [63:0] pl;
		logic [31:0] ph;
		logic [63:0] ss;
		logic [63:0] c2;
		logic [63:0] ql;
		logic [31:0] qh;
		logic [63:0] c1;
		logic [63:0] r;
		logic [31:0] pres;
		logic        neg;
		side_t       side;
	} post_t;

	function automatic post_t post_step(input int unsigned k, input post_t i, input coef_t c);
		post_t              o;
		logic signed [47:0] pr48;
		logic signed [48:0] pr49;
		logic        [63:0] pu64;
		logic signed [63:0] s64a;
		o = i;
		case (k)
			1: begin
				o.p = i.neg ? (64'd0 - i.p) : i.p;
			end
			2: begin
				// s * s from 32-bit halves, low 64 bits only
				s64a = $signed(i.p) >>> 13;
				pu64 = s64a[31:0] * s64a[31:0];
				o.ll = pu64;
				pu64 = s64a[31:0] * s64a[63:32];
				o.lh = pu64[31:0];
				pr49 = $signed({1'b0, i.p[31:0]}) * $signed(c.p8);
				o.pl = {{15{pr49[48]}}, pr49};
				pr48 = $signed(i.p[63:32]) * $signed(c.p8);
				o.ph = pr48[31:0];
			end
			3: begin
				o.ss = i.ll + {i.lh[30:0], 33'b0};
				s64a = $signed(i.pl + {i.ph, 32'b0}) >>> 19;
				o.c2 = s64a;
			end
			4: begin
				pr49 = $signed({1'b0, i.ss[31:0]}) * $signed(c.p9);
				o.ql = {{15{pr49[48]}}, pr49};
				pr48 = $signed(i.ss[63:32]) * $signed(c.p9);
				o.qh = pr48[31:0];
			end
			5: begin
				s64a = $signed(i.ql + {i.qh, 32'b0}) >>> 25;
				o.c1 = s64a;
			end
			6: begin
				s64a = $signed(i.p + i.c1 + i.c2) >>> 8;
				o.r  = s64a + {{44{c.p7[15]}}, c.p7, 4'b0};
			end
			7: begin
				s64a   = $signed(i.r) >>> 8;
				o.pres = i.side.inval ? 32'd0 : s64a[31:0];
			end
			default: begin
				o = i;
			end
		endcase
		return o;
	endfunction

	post_t               post_in;
	post_t               post_d [1:PostStages];
	post_t               post_s [1:PostStages];
	logic [PostStages:1] vld_s;

	always_comb begin
		post_in      = '0;
		post_in.p    = in_item.quo;
		post_in.neg  = in_item.neg;
		post_in.side = in_item.side;
	end

	for (genvar g = 1; g <= PostStages; g++) begin : g_stage
		if (g == 1) begin : g_first
			assign post_d[g] = post_step(g, post_in, coef);
		end else begin : g_next
			assign post_d[g] = post_step(g, post_s[g-1], coef);
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				post_s[g] <= post_d[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[PostStages-1:1], in_valid};
		end
	end

	assign out_valid = vld_s[PostStages];
	assign out_side  = post_s[PostStages].side;
	assign out_pres  = post_s[PostStages].pres;

endmodule

FILE: src/env_sensor_compensation_unit.sv
// Integer compensation of raw temperature, pressure and humidity readings. One item is taken
// every cycle while the input queue is not full; results leave in order, one per item, after
// 14 stages of multiply/add for temperature, humidity and the pressure terms, the 64-stage
// pipelined pressure divider plus its entry stage, and 7 stages of pressure correction ending in
// the result register. A two-entry input queue buffers readings while a result waits. The user
// must write coefficients through the cfg port while no item is in flight; this is not enforced.
// depends on escu_pkg, escu_front, escu_pre, escu_div, escu_post
module env_sensor_compensation_unit import escu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic [19:0]        raw_temperature,
	input  logic [19:0]        raw_pressure,
	input  logic [15:0]        raw_humidity,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] temperature_centi,
	output logic [31:0]        pressure_pa,
	output logic               pressure_invalid,
	output logic [16:0]        humidity_q10
);

	logic [47:0] temp_coeffs_q;
	logic [63:0] press_lo_q;
	logic [63:0] press_hi_q;
	logic [47:0] press_hum_q;
	logic [31:0] hum_coeffs_q;
	coef_t       coef;

	raw_t        push_item;
	raw_t        head_item;
	logic        head_valid;
	logic        adv;
	logic        pre_valid;
	div_in_t     pre_item;
	logic        div_valid;
	div_out_t    div_item;
	side_t       res_side;
	logic [31:0] res_pres;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_lo_q    <= '0;
			press_hi_q    <= '0;
			press_hum_q   <= '0;
			hum_coeffs_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEMP:      temp_coeffs_q <= cfg_data[47:0];
				REG_PRESS_LO:  press_lo_q    <= cfg_data;
				REG_PRESS_HI:  press_hi_q    <= cfg_data;
				REG_PRESS_HUM: press_hum_q   <= cfg_data[47:0];
				REG_HUM:       hum_coeffs_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		coef.t1 = temp_coeffs_q[15:0];
		coef.t2 = temp_coeffs_q[31:16];
		coef.t3 = temp_coeffs_q[47:32];
		coef.p1 = press_lo_q[15:0];
		coef.p2 = press_lo_q[31:16];
		coef.p3 = press_lo_q[47:32];
		coef.p4 = press_lo_q[63:48];
		coef.p5 = press_hi_q[15:0];
		coef.p6 = press_hi_q[31:16];
		coef.p7 = press_hi_q[47:32];
		coef.p8 = press_hi_q[63:48];
		coef.p9 = press_hum_q[15:0];
		coef.h1 = press_hum_q[23:16];
		coef.h2 = press_hum_q[39:24];
		coef.h3 = press_hum_q[47:40];
		coef.h4 = hum_coeffs_q[11:0];
		coef.h5 = hum_coeffs_q[23:12];
		coef.h6 = hum_coeffs_q[31:24];
	end

	// whole back pipeline moves together unless the result register is held
	assign adv = !result_valid || !result_stall;

	assign push_item.at = raw_temperature;
	assign push_item.ap = raw_pressure;
	assign push_item.ah = raw_humidity;

	escu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (sample_valid),
		.push_item  (push_item),
		.full       (sample_stall),
		.pop        (adv),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	escu_pre u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (head_valid),
		.in_raw    (head_item),
		.coef      (coef),
		.out_valid (pre_valid),
		.out_item  (pre_item)
	);

	escu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (pre_valid),
		.in_item   (pre_item),
		.out_valid (div_valid),
		.out_item  (div_item)
	);

	escu_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (div_valid),
		.in_item   (div_item),
		.coef      (coef),
		.out_valid (result_valid),
		.out_side  (res_side),
		.out_pres  (res_pres)
	);

	assign temperature_centi = res_side.temp;
	assign pressure_pa       = res_pres;
	assign pressure_invalid  = res_side.inval;
	assign humidity_q10      = res_side.hum;

endmodule
